>>> rtl/segmented_offset_patch_engine_assert.svh
// Assertion macros shared by the segmented offset patch engine RTL.
// Depends on nothing; the using module must provide signals named clock and reset.
`ifndef SEGMENTED_OFFSET_PATCH_ENGINE_ASSERT_SVH
`define SEGMENTED_OFFSET_PATCH_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high
`define SOPE_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sope: same-cycle check failed");
// Next-cycle implication, disabled while reset is high
`define SOPE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sope: next-cycle check failed");
`else
`define SOPE_ASSERT_IMPL(label, ante, cons)
`define SOPE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/sope_pkg.sv
// Shared constants, action codes and control structs of the segmented offset patch engine.
// Depends on nothing; used by the interfaces and by every module of the block but sope_ram.
`timescale 1ns / 1ps

package sope_pkg;

   // Default sizes
   localparam int MAX_SEGMENTS_DEF    = 64;
   localparam int STORE_ADDR_BITS_DEF = 16;

   // Fixed field widths
   localparam int ACT_W  = 2;
   localparam int ADDR_W = 32;
   localparam int BYTE_W = 8;
   localparam int HIT_W  = 6;

   // Action codes
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
   localparam logic [ACT_W-1:0] ACT_PATCH  = 2'd2;

   // Command into the segment walker
   typedef struct packed {
      logic              clear;
      logic              append;
      logic              walk;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] length;
      logic [ADDR_W-1:0] offset;
   } seg_cmd_type;

   // Status and walk result from the segment walker
   typedef struct packed {
      logic              full;
      logic              empty;
      logic              done;
      logic              hit;
      logic [ADDR_W-1:0] phys;
      logic [HIT_W-1:0]  hit_idx;
   } seg_stat_type;

   // Read-compare-write request into the byte store
   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] new_byte;
      logic [BYTE_W-1:0] expected_byte;
   } store_req_type;

   // Byte store status and result
   typedef struct packed {
      logic busy;
      logic done;
      logic ok;
   } store_res_type;

endpackage

>>> rtl/sope_req_if.sv
// Request channel of the segmented offset patch engine: valid/ready plus one action item.
// Depends on sope_pkg.
`timescale 1ns / 1ps

interface sope_req_if;
   import sope_pkg::*;

   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [ADDR_W-1:0] segment_base;
   logic [ADDR_W-1:0] segment_length;
   logic [ADDR_W-1:0] logical_offset;
   logic [BYTE_W-1:0] new_byte;
   logic [BYTE_W-1:0] expected_byte;

   modport source (
      output valid, action, segment_base, segment_length, logical_offset,
             new_byte, expected_byte,
      input  ready
   );

   modport sink (
      input  valid, action, segment_base, segment_length, logical_offset,
             new_byte, expected_byte,
      output ready
   );
endinterface

>>> rtl/sope_rsp_if.sv
// Response channel of the segmented offset patch engine: valid/ready plus one result item.
// Depends on sope_pkg.
`timescale 1ns / 1ps

interface sope_rsp_if;
   import sope_pkg::*;

   logic              valid;
   logic              ready;
   logic              ok;
   logic              written;
   logic [ADDR_W-1:0] physical_address;
   logic [HIT_W-1:0]  segment_hit;

   modport source (
      output valid, ok, written, physical_address, segment_hit,
      input  ready
   );

   modport sink (
      input  valid, ok, written, physical_address, segment_hit,
      output ready
   );
endinterface

>>> rtl/sope_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module sope_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sope_seg_walker.sv
// Segment table (base and length per entry in one RAM) with its fill count and offset walk.
// Depends on sope_pkg, sope_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "segmented_offset_patch_engine_assert.svh"

module sope_seg_walker #(
   parameter int MAX_SEGMENTS = sope_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sope_pkg::seg_cmd_type cmd,
   output sope_pkg::seg_stat_type stat
);
   import sope_pkg::*;

   localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam int ENT_W = 2 * ADDR_W;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              walking_ff, walking_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0] rem_ff, rem_in;
   logic              done_ff, done_in;
   logic              hit_ff, hit_in;
   logic [ADDR_W-1:0] phys_ff, phys_in;
   logic [HIT_W-1:0]  hit_idx_ff, hit_idx_in;

   logic [IDX_W-1:0]  rd_addr;
   logic [ENT_W-1:0]  rd_entry;
   logic [ADDR_W-1:0] ent_base;
   logic [ADDR_W-1:0] ent_len;
   logic [CNT_W-1:0]  next_cnt;
   logic              step;

   // Table storage: base in the upper half, length in the lower half
   sope_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_SEGMENTS),
      .AW    (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.append),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({cmd.base, cmd.length}),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   assign ent_base = rd_entry[ENT_W-1:ADDR_W];
   assign ent_len  = rd_entry[ADDR_W-1:0];

   // Prefetch the following entry so the walk covers one entry per cycle
   assign rd_addr  = walking_ff ? (idx_ff + IDX_W'(1)) : '0;
   assign next_cnt = CNT_W'(idx_ff) + CNT_W'(1);
   assign step     = (ent_len <= rem_ff) && (next_cnt < count_ff);

   // Table count, walk sequencing and walk result
   always_comb begin
      count_in   = count_ff;
      walking_in = walking_ff;
      idx_in     = idx_ff;
      rem_in     = rem_ff;
      done_in    = 1'b0;
      hit_in     = hit_ff;
      phys_in    = phys_ff;
      hit_idx_in = hit_idx_ff;

      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.walk) begin
         walking_in = 1'b1;
         idx_in     = '0;
         rem_in     = cmd.offset;
      end

      if (walking_ff) begin
         if (step) begin
            rem_in = rem_ff - ent_len;
            idx_in = idx_ff + IDX_W'(1);
         end else begin
            walking_in = 1'b0;
            done_in    = 1'b1;
            hit_in     = rem_ff < ent_len;
            phys_in    = rem_ff + ent_base;
            hit_idx_in = HIT_W'(idx_ff);
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         walking_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         count_ff   <= count_in;
         walking_ff <= walking_in;
         done_ff    <= done_in;
      end
   end

   // Walk payload registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      rem_ff     <= rem_in;
      hit_ff     <= hit_in;
      phys_ff    <= phys_in;
      hit_idx_ff <= hit_idx_in;
   end

   assign stat.full    = count_ff == CNT_W'(MAX_SEGMENTS);
   assign stat.empty   = count_ff == '0;
   assign stat.done    = done_ff;
   assign stat.hit     = hit_ff;
   assign stat.phys    = phys_ff;
   assign stat.hit_idx = hit_idx_ff;

   `SOPE_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= CNT_W'(MAX_SEGMENTS))
   `SOPE_ASSERT_IMPL(a_walk_in_table, walking_ff, CNT_W'(idx_ff) < count_ff)
   `SOPE_ASSERT_NEXT(a_append_counts, cmd.append && !cmd.clear, count_ff != '0)

endmodule

>>> rtl/sope_byte_store.sv
// Byte store RAM with its post-reset clearing pass and the read-compare-write of one patch.
// Depends on sope_pkg, sope_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "segmented_offset_patch_engine_assert.svh"

module sope_byte_store #(
   parameter int STORE_ADDR_BITS = sope_pkg::STORE_ADDR_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  sope_pkg::store_req_type req,
   output sope_pkg::store_res_type res
);
   import sope_pkg::*;

   localparam int DEPTH = 1 << STORE_ADDR_BITS;

   logic                       clearing_ff, clearing_in;
   logic [STORE_ADDR_BITS-1:0] clr_ptr_ff, clr_ptr_in;
   logic                       pending_ff, pending_in;
   logic [STORE_ADDR_BITS-1:0] addr_ff, addr_in;
   logic [BYTE_W-1:0]          new_ff, new_in;
   logic [BYTE_W-1:0]          exp_ff, exp_in;
   logic                       done_ff, done_in;
   logic                       ok_ff, ok_in;

   logic                       wr_en;
   logic [STORE_ADDR_BITS-1:0] wr_addr;
   logic [BYTE_W-1:0]          wr_data;
   logic [BYTE_W-1:0]          rd_data;

   // Write port: zero fill during the clearing pass, else the patch byte
   always_comb begin
      if (clearing_ff) begin
         wr_en   = 1'b1;
         wr_addr = clr_ptr_ff;
         wr_data = '0;
      end else begin
         wr_en   = pending_ff;
         wr_addr = addr_ff;
         wr_data = new_ff;
      end
   end

   sope_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH),
      .AW    (STORE_ADDR_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (req.addr[STORE_ADDR_BITS-1:0]),
      .rd_data (rd_data)
   );

   // Clearing sweep, request capture and compare
   always_comb begin
      clearing_in = clearing_ff;
      clr_ptr_in  = clr_ptr_ff;
      pending_in  = 1'b0;
      addr_in     = addr_ff;
      new_in      = new_ff;
      exp_in      = exp_ff;
      done_in     = 1'b0;
      ok_in       = ok_ff;

      if (clearing_ff) begin
         clr_ptr_in = clr_ptr_ff + STORE_ADDR_BITS'(1);
         if (clr_ptr_ff == '1) begin
            clearing_in = 1'b0;
         end
      end

      if (req.start) begin
         pending_in = 1'b1;
         addr_in    = req.addr[STORE_ADDR_BITS-1:0];
         new_in     = req.new_byte;
         exp_in     = req.expected_byte;
      end

      if (pending_ff) begin
         done_in = 1'b1;
         ok_in   = rd_data == exp_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ptr_ff  <= '0;
         pending_ff  <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ptr_ff  <= clr_ptr_in;
         pending_ff  <= pending_in;
         done_ff     <= done_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      new_ff  <= new_in;
      exp_ff  <= exp_in;
      ok_ff   <= ok_in;
   end

   assign res.busy = clearing_ff;
   assign res.done = done_ff;
   assign res.ok   = ok_ff;

   `SOPE_ASSERT_IMPL(a_no_patch_while_clearing, req.start || pending_ff, !clearing_ff)

endmodule

>>> rtl/segmented_offset_patch_engine.sv
// Segmented offset patch engine: a segment table plus a patchable byte store behind a
// valid/ready request channel and a registered response channel.
// Depends on sope_pkg, sope_req_if, sope_rsp_if, sope_seg_walker and sope_byte_store.
//
// The engine keeps up to MAX_SEGMENTS (base, length) segments that form one logical image
// and a byte store of 2^STORE_ADDR_BITS bytes addressed by the low bits of a physical address.
// Clear, append and unused action codes go from the transfer straight to the response. A patch
// walks the segment table one entry per cycle through the table RAM read port, then reads,
// compares and writes the byte store; a patch past the image skips the byte store, and a
// patch on an empty table goes straight to the response. One item is in work at a time; the
// response register holds a finished result while the next item transfers.
// After reset the byte store is zeroed by a sweep over its 2^STORE_ADDR_BITS bytes, during
// which req_ch.ready stays low.
`timescale 1ns / 1ps
`include "segmented_offset_patch_engine_assert.svh"

module segmented_offset_patch_engine #(
   parameter int MAX_SEGMENTS    = sope_pkg::MAX_SEGMENTS_DEF,
   parameter int STORE_ADDR_BITS = sope_pkg::STORE_ADDR_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sope_req_if.sink   req_ch,
   sope_rsp_if.source rsp_ch
);
   import sope_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WALK  = 4'b0010,
      ST_STORE = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   typedef struct packed {
      logic              ok;
      logic              written;
      logic [ADDR_W-1:0] phys;
      logic [HIT_W-1:0]  hit;
   } result_type;

   state_type         state_ff, state_in;
   result_type        pend_ff, pend_in;
   result_type        out_ff, out_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] new_ff, new_in;
   logic [BYTE_W-1:0] exp_ff, exp_in;

   seg_cmd_type       seg_cmd;
   seg_stat_type      seg_stat;
   store_req_type     store_req;
   store_res_type     store_res;
   logic              accept;
   logic              slot_free;

   sope_seg_walker #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_walker (
      .clock (clock),
      .reset (reset),
      .cmd   (seg_cmd),
      .stat  (seg_stat)
   );

   sope_byte_store #(
      .STORE_ADDR_BITS (STORE_ADDR_BITS)
   ) u_store (
      .clock (clock),
      .reset (reset),
      .req   (store_req),
      .res   (store_res)
   );

   assign req_ch.ready = (state_ff == ST_IDLE) && !store_res.busy;
   assign accept       = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   // Sequence one item: dispatch, walk, byte update, hand off to the response register
   always_comb begin
      state_in        = state_ff;
      pend_in         = pend_ff;
      out_in          = out_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ch.ready;
      new_in          = new_ff;
      exp_in          = exp_ff;

      seg_cmd.clear   = 1'b0;
      seg_cmd.append  = 1'b0;
      seg_cmd.walk    = 1'b0;
      seg_cmd.base    = req_ch.segment_base;
      seg_cmd.length  = req_ch.segment_length;
      seg_cmd.offset  = req_ch.logical_offset;

      store_req.start         = 1'b0;
      store_req.addr          = seg_stat.phys;
      store_req.new_byte      = new_ff;
      store_req.expected_byte = exp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pend_in  = '{ok: 1'b1, written: 1'b0, phys: '0, hit: '0};
               state_in = ST_EMIT;
               case (req_ch.action)
                  ACT_CLEAR: begin
                     seg_cmd.clear = 1'b1;
                  end
                  ACT_APPEND: begin
                     if (seg_stat.full) begin
                        pend_in.ok = 1'b0;
                     end else begin
                        seg_cmd.append = 1'b1;
                     end
                  end
                  ACT_PATCH: begin
                     if (!seg_stat.empty) begin
                        seg_cmd.walk = 1'b1;
                        new_in       = req_ch.new_byte;
                        exp_in       = req_ch.expected_byte;
                        state_in     = ST_WALK;
                     end
                  end
                  default: begin
                     // unused code: plain acknowledge
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (seg_stat.done) begin
               if (seg_stat.hit) begin
                  store_req.start = 1'b1;
                  pend_in.written = 1'b1;
                  pend_in.phys    = seg_stat.phys;
                  pend_in.hit     = seg_stat.hit_idx;
                  state_in        = ST_STORE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_STORE: begin
            if (store_res.done) begin
               pend_in.ok = store_res.ok;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               out_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
      new_ff  <= new_in;
      exp_ff  <= exp_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.ok               = out_ff.ok;
   assign rsp_ch.written          = out_ff.written;
   assign rsp_ch.physical_address = out_ff.phys;
   assign rsp_ch.segment_hit      = out_ff.hit;

   `SOPE_ASSERT_IMPL(a_walk_done_in_walk, seg_stat.done, state_ff == ST_WALK)
   `SOPE_ASSERT_IMPL(a_store_done_in_store, store_res.done, state_ff == ST_STORE)

endmodule

>>> bench/tb_segmented_offset_patch_engine.sv
// Testbench for the segmented offset patch engine: directed and random action streams with
// a built-in translation and byte-store predictor, checked result by result.
// Depends on sope_pkg, sope_req_if, sope_rsp_if and the segmented_offset_patch_engine RTL.
`timescale 1ns / 1ps

module tb_segmented_offset_patch_engine;
   import sope_pkg::*;

   localparam int MAX_SEG       = MAX_SEGMENTS_DEF;
   localparam int STORE_BITS    = STORE_ADDR_BITS_DEF;
   localparam int STORE_BYTES   = 1 << STORE_BITS;
   localparam int SETTLE_CYCLES = MAX_SEG + 10;
   localparam int RANDOM_ITEMS  = 1040;
   localparam int LONG_HOLD     = 300;
   localparam int REPORT_LIMIT  = 10;

   // Action code the block leaves unused
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic [ACT_W-1:0]  action;
      logic [ADDR_W-1:0] base;
      logic [ADDR_W-1:0] length;
      logic [ADDR_W-1:0] offset;
      logic [BYTE_W-1:0] new_byte;
      logic [BYTE_W-1:0] expected_byte;
   } action_item_type;

   typedef struct {
      logic              ok;
      logic              written;
      logic [ADDR_W-1:0] phys;
      logic [HIT_W-1:0]  hit;
   } outcome_type;

   logic clock;
   logic reset;

   sope_req_if req_ch ();
   sope_rsp_if rsp_ch ();

   segmented_offset_patch_engine uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Mirror of the segment table and byte store
   logic [ADDR_W-1:0] seg_base_mirror [MAX_SEG];
   logic [ADDR_W-1:0] seg_len_mirror  [MAX_SEG];
   int                seg_count_mirror;
   logic [BYTE_W-1:0] store_mirror [STORE_BYTES];
   outcome_type       expected_outcomes [$];

   // Idling controls shared by the sender, the receiver and the tests
   bit req_idle;
   bit rsp_idle;
   int rsp_hold_left;

   // Run statistics
   int n_items;
   int n_checked;
   int n_written;
   int n_stale;
   int n_beyond;
   int n_rejected;
   int mismatch_count;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Walk the mirrored table; return 1 with the physical address when the offset is mapped
   function automatic bit locate_byte(input logic [ADDR_W-1:0] offset,
                                      output logic [ADDR_W-1:0] phys, output int idx);
      logic [ADDR_W-1:0] rem;
      idx  = 0;
      rem  = offset;
      phys = '0;
      if (seg_count_mirror == 0) return 1'b0;
      while (seg_len_mirror[idx] <= rem && idx + 1 < seg_count_mirror) begin
         rem -= seg_len_mirror[idx];
         idx++;
      end
      if (rem < seg_len_mirror[idx]) begin
         phys = rem + seg_base_mirror[idx];
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Apply one accepted action to the mirror and return the result it must produce
   function automatic outcome_type apply_action(input action_item_type it);
      outcome_type       res;
      logic [ADDR_W-1:0] phys;
      int                idx;
      res = '{ok: 1'b1, written: 1'b0, phys: '0, hit: '0};
      case (it.action)
         ACT_CLEAR: begin
            seg_count_mirror = 0;
         end
         ACT_APPEND: begin
            if (seg_count_mirror >= MAX_SEG) begin
               res.ok = 1'b0;
               n_rejected++;
            end else begin
               seg_base_mirror[seg_count_mirror] = it.base;
               seg_len_mirror[seg_count_mirror]  = it.length;
               seg_count_mirror++;
            end
         end
         ACT_PATCH: begin
            if (locate_byte(it.offset, phys, idx)) begin
               res.ok      = (store_mirror[phys[STORE_BITS-1:0]] == it.expected_byte);
               res.written = 1'b1;
               res.phys    = phys;
               res.hit     = idx[HIT_W-1:0];
               store_mirror[phys[STORE_BITS-1:0]] = it.new_byte;
               n_written++;
               if (!res.ok) n_stale++;
            end else if (seg_count_mirror > 0) begin
               n_beyond++;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Sum of the segment lengths below index upto, modulo 2^32
   function automatic logic [ADDR_W-1:0] image_prefix(input int upto);
      logic [ADDR_W-1:0] sum;
      sum = '0;
      for (int i = 0; i < upto; i++) sum += seg_len_mirror[i];
      return sum;
   endfunction

   function automatic action_item_type action_item(input logic [ACT_W-1:0] action,
         input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] length,
         input logic [ADDR_W-1:0] offset, input logic [BYTE_W-1:0] new_byte,
         input logic [BYTE_W-1:0] expected_byte);
      action_item_type it;
      it.action        = action;
      it.base          = base;
      it.length        = length;
      it.offset        = offset;
      it.new_byte      = new_byte;
      it.expected_byte = expected_byte;
      return it;
   endfunction

   function automatic action_item_type random_noise();
      return action_item(ACT_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                         BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
   endfunction

   // Append with bases spread over the address space, near the store start and near wrap
   function automatic action_item_type random_append();
      action_item_type it;
      it = random_noise();
      it.action = ACT_APPEND;
      case ($urandom_range(0, 3))
         0: it.base = $urandom_range(0, 511);
         1: it.base = 32'hFFFF_FF00 + $urandom_range(0, 255);
         default: it.base = $urandom;
      endcase
      case ($urandom_range(0, 7))
         0: it.length = '0;
         1: it.length = $urandom;
         default: it.length = $urandom_range(1, 64);
      endcase
      return it;
   endfunction

   // Patch mostly inside the image, sometimes just past it or anywhere
   function automatic action_item_type random_patch();
      action_item_type   it;
      logic [ADDR_W-1:0] phys;
      int                idx;
      it = random_noise();
      it.action = ACT_PATCH;
      if (seg_count_mirror > 0 && $urandom_range(0, 7) != 0) begin
         if ($urandom_range(0, 9) == 0) begin
            it.offset = image_prefix(seg_count_mirror) + $urandom_range(0, 15);
         end else begin
            idx = $urandom_range(0, seg_count_mirror - 1);
            it.offset = image_prefix(idx);
            if (seg_len_mirror[idx] != 0)
               it.offset += $urandom_range(0, seg_len_mirror[idx] - 1);
         end
      end
      // Expect the stored byte most of the time so both match outcomes occur
      if (locate_byte(it.offset, phys, idx) && $urandom_range(0, 3) != 0)
         it.expected_byte = store_mirror[phys[STORE_BITS-1:0]];
      return it;
   endfunction

   // Offer one action, after a random gap when req_idle is set, and predict its result at the transfer
   task automatic send_action(input action_item_type it);
      int gap;
      gap = req_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.action         <= it.action;
      req_ch.segment_base   <= it.base;
      req_ch.segment_length <= it.length;
      req_ch.logical_offset <= it.offset;
      req_ch.new_byte       <= it.new_byte;
      req_ch.expected_byte  <= it.expected_byte;
      do @(posedge clock); while (!req_ch.ready);
      expected_outcomes.push_back(apply_action(it));
      n_items++;
   endtask

   // Drop valid and wait until every predicted result has come back
   task automatic drain_outcomes();
      req_ch.valid <= 1'b0;
      while (expected_outcomes.size() > 0) @(posedge clock);
   endtask

   // Receiver: random stalls per result, plus a long hold-off on request
   always @(posedge clock) begin : drive_rsp_ready
      int stall_left;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            stall_left = rsp_idle ? $urandom_range(0, 9) : 0;
         if (rsp_hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_left--;
         end else if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin : check_rsp
      outcome_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: result with nothing pending: ok=%0b written=%0b addr=%h hit=%0d",
                        $time, rsp_ch.ok, rsp_ch.written, rsp_ch.physical_address,
                        rsp_ch.segment_hit);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_ch.ok !== want.ok || rsp_ch.written !== want.written ||
                rsp_ch.physical_address !== want.phys || rsp_ch.segment_hit !== want.hit) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: expected ok=%0b written=%0b addr=%h hit=%0d, got ok=%0b %s",
                           $time, want.ok, want.written, want.phys, want.hit, rsp_ch.ok,
                           $sformatf("written=%0b addr=%h hit=%0d", rsp_ch.written,
                                     rsp_ch.physical_address, rsp_ch.segment_hit));
            end else begin
               n_checked++;
            end
         end
      end
   end

   // Empty table: patches write nothing; clear and the unused code just acknowledge
   task automatic test_empty_table();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      send_action(action_item(ACT_PATCH, '0, '0, '0, 8'hFF, 8'hFF));
      send_action(action_item(ACT_CLEAR, '1, '1, '1, 8'hFF, 8'hFF));
      send_action(action_item(ACT_UNUSED, '1, '1, '1, 8'hFF, 8'hFF));
      send_action(action_item(ACT_PATCH, '1, '1, '1, 8'h00, 8'h00));
      drain_outcomes();
   endtask

   // Address wrap, zero-length segment, segment boundaries, past the image, huge segment
   task automatic test_translation_edges();
      send_action(action_item(ACT_APPEND, 32'hFFFF_FFF0, 32'h20, '0, '0, '0));
      send_action(action_item(ACT_APPEND, 32'hABCD_0000, '0, '0, '0, '0));
      send_action(action_item(ACT_APPEND, 32'h0001_0005, 32'h3, '0, '0, '0));
      send_action(action_item(ACT_PATCH, '0, '0, 32'h0, 8'hFF, 8'h00));
      send_action(action_item(ACT_PATCH, '0, '0, 32'h0, 8'h00, 8'h00));
      send_action(action_item(ACT_PATCH, '0, '0, 32'h10, 8'hA5, 8'h00));
      send_action(action_item(ACT_PATCH, '0, '0, 32'h1F, 8'h5A, 8'hFF));
      send_action(action_item(ACT_PATCH, '0, '0, 32'h20, 8'h3C, 8'h00));
      send_action(action_item(ACT_PATCH, '0, '0, 32'h22, 8'h81, 8'h00));
      send_action(action_item(ACT_PATCH, '0, '0, 32'h23, 8'h11, 8'h22));
      send_action(action_item(ACT_PATCH, '0, '0, 32'hFFFF_FFFF, 8'h11, 8'h22));
      send_action(action_item(ACT_APPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0));
      send_action(action_item(ACT_PATCH, '0, '0, 32'hFFFF_FFFF, 8'h00, 8'hFF));
      send_action(action_item(ACT_PATCH, '0, '0, 32'h10, 8'h00, 8'hA5));
      send_action(action_item(ACT_CLEAR, '0, '0, '0, '0, '0));
      drain_outcomes();
   endtask

   // Fill all segments without idling, refuse further appends, patch where the last segment starts
   task automatic test_full_table();
      action_item_type it;
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      send_action(action_item(ACT_CLEAR, '0, '0, '0, '0, '0));
      for (int i = 0; i < MAX_SEG; i++) begin
         it = random_append();
         if (i == MAX_SEG - 1) it.length = $urandom_range(1, 64);
         send_action(it);
      end
      send_action(random_append());
      send_action(random_append());
      it = random_patch();
      it.offset = image_prefix(MAX_SEG - 1);
      send_action(it);
      repeat (8) send_action(random_patch());
      drain_outcomes();
   endtask

   // Hold the receiver off while the sender keeps offering, so the input stalls
   task automatic test_backpressure();
      req_idle = 1'b0;
      rsp_idle = 1'b1;
      send_action(action_item(ACT_CLEAR, '0, '0, '0, '0, '0));
      repeat (4) send_action(random_append());
      rsp_hold_left = LONG_HOLD;
      repeat (12) send_action(random_patch());
      drain_outcomes();
   endtask

   // Well-formed clear/append/patch sequences with random content and some noise
   task automatic test_random_sequences(input int target);
      int first;
      int n_seg;
      int n_patch;
      first = n_items;
      while (n_items - first < target) begin
         req_idle = ($urandom_range(0, 3) != 0);
         rsp_idle = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 5) != 0)
            send_action(action_item(ACT_CLEAR, $urandom, $urandom, $urandom,
                                    BYTE_W'($urandom_range(0, 255)),
                                    BYTE_W'($urandom_range(0, 255))));
         n_seg = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_SEG + 4)
                                             : $urandom_range(1, 8);
         repeat (n_seg) send_action(random_append());
         n_patch = $urandom_range(4, 24);
         repeat (n_patch) begin
            if ($urandom_range(0, 15) == 0) send_action(random_noise());
            else send_action(random_patch());
         end
      end
      drain_outcomes();
   endtask

   initial begin
      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.action         <= ACT_CLEAR;
      req_ch.segment_base   <= '0;
      req_ch.segment_length <= '0;
      req_ch.logical_offset <= '0;
      req_ch.new_byte       <= '0;
      req_ch.expected_byte  <= '0;
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      rsp_hold_left = 0;
      seg_count_mirror = 0;
      for (int i = 0; i < MAX_SEG; i++) begin
         seg_base_mirror[i] = '0;
         seg_len_mirror[i]  = '0;
      end
      for (int i = 0; i < STORE_BYTES; i++) store_mirror[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_translation_edges();
      test_full_table();
      test_backpressure();
      test_random_sequences(RANDOM_ITEMS);

      // Let any stray result surface before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d actions: %0d bytes patched, %0d of them over a stale old byte,",
               n_items, n_written, n_stale);
      $display("%0d offsets past the image, %0d appends refused, %0d results matched.",
               n_beyond, n_rejected, n_checked);
      if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
         $display("segmented_offset_patch_engine test passed");
      end else begin
         $display("segmented_offset_patch_engine test failed");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #8ms;
      $display("segmented_offset_patch_engine test failed");
      $finish;
   end

endmodule
